### hw/rtl/bsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types and constants for the safety allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

  localparam int unsigned DefNumSlots = 16;
  localparam int unsigned DefNumTypes = 4;
  localparam int unsigned UnitW       = 16;
  localparam int unsigned NumRegs     = 4;
  localparam int unsigned FuncW       = 2;
  localparam int unsigned SlotW       = 4;
  localparam int unsigned CfgIdxW     = 2;

  typedef enum logic [FuncW-1:0] {
    FUNC_NEW  = 2'd0,
    FUNC_REQ  = 2'd1,
    FUNC_TERM = 2'd2,
    FUNC_BAD  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CHK,
    ST_SCAN,
    ST_APPLY,
    ST_OUT
  } state_t;

  typedef logic [UnitW-1:0] unit_t;

  // per-slot test result from the lane array
  typedef struct packed {
    logic fits;
    logic any_over;
  } lane_stat_t;

endpackage

### hw/rtl/bsa_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_in_if / bsa_out_if
// Valid/ready channels for commands and results.
// ----------------------------------------------------------------------------
interface bsa_in_if;
  logic                valid;
  logic                ready;
  logic [1:0]          func;
  logic [3:0]          slot;
  logic [15:0]         amount_0;
  logic [15:0]         amount_1;
  logic [15:0]         amount_2;
  logic [15:0]         amount_3;
  modport source (output valid, func, slot, amount_0, amount_1, amount_2, amount_3,
                  input ready);
  modport sink   (input valid, func, slot, amount_0, amount_1, amount_2, amount_3,
                  output ready);
endinterface

interface bsa_out_if;
  logic valid;
  logic ready;
  logic ok;
  modport source (output valid, ok, input ready);
  modport sink   (input valid, ok, output ready);
endinterface

### hw/rtl/bsa_lanes.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_lanes
// One lane per resource type: need-vs-work compare and work update for
// the slot under test, merged into a single fits flag.
// ----------------------------------------------------------------------------
module bsa_lanes #(
  parameter int unsigned NUM_TYPES = bsa_pkg::DefNumTypes
) (
  input  bsa_pkg::unit_t     claim_i [NUM_TYPES],
  input  bsa_pkg::unit_t     held_i  [NUM_TYPES],
  input  bsa_pkg::unit_t     work_i  [NUM_TYPES],
  output bsa_pkg::unit_t     work_o  [NUM_TYPES],
  output bsa_pkg::lane_stat_t stat_o
);
  import bsa_pkg::*;

  logic [NUM_TYPES-1:0] fit_v;
  logic [NUM_TYPES-1:0] over_v;

  for (genvar t = 0; t < NUM_TYPES; t++) begin : g_lane
    logic [UnitW-1:0] need;
    logic [UnitW:0]   sum;
    assign need     = claim_i[t] - held_i[t];
    assign fit_v[t] = (need <= work_i[t]);
    assign over_v[t] = (held_i[t] > claim_i[t]);
    assign sum      = {1'b0, work_i[t]} + {1'b0, held_i[t]};
    assign work_o[t] = sum[UnitW] ? {UnitW{1'b1}} : sum[UnitW-1:0];
  end

  assign stat_o.fits     = &fit_v;
  assign stat_o.any_over = |over_v;
endmodule

### hw/rtl/bankers_safety_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bankers_safety_allocator
// Banker's-algorithm admission control over a table of process slots.
// ----------------------------------------------------------------------------
// channel   dir  handshake      payload
// in_*      in   valid/ready    func, slot, amount_0..3
// out_*     out  valid/ready    ok
// cfg_*     in   we only        idx, data (total units per type)
//
// One item at a time. NEW/TERMINATE pass through read, check, apply and output steps;
// REQUEST adds the scan, which visits each slot in turn (registered table
// read, then all types compared in parallel lanes) for up to NUM_SLOTS passes
// of NUM_SLOTS slots.
// Input is taken again once back in idle; a result still waiting at the
// output stalls only the next item's output step.
// Synchronous active-low reset clears control and slot-in-use bits.
// Claim/held tables have no reset; they are written by NEW before use.
// ----------------------------------------------------------------------------
module bankers_safety_allocator #(
  parameter int unsigned NUM_SLOTS = bsa_pkg::DefNumSlots,
  parameter int unsigned NUM_TYPES = bsa_pkg::DefNumTypes
) (
  input  logic                       clk,
  input  logic                       rst_n,
  bsa_in_if.sink                     in_ch,
  bsa_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [bsa_pkg::CfgIdxW-1:0] cfg_idx,
  input  logic [bsa_pkg::UnitW-1:0]  cfg_data
);
  import bsa_pkg::*;

  localparam int unsigned SIW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  state_t state_r, state_nxt;

  unit_t total_r [NUM_TYPES];
  unit_t held_tot_r [NUM_TYPES];
  unit_t work_r [NUM_TYPES];
  unit_t amt_r [NUM_TYPES];
  unit_t claim_q_r [NUM_TYPES];
  unit_t held_q_r [NUM_TYPES];
  logic [NUM_SLOTS-1:0] in_use_r, fin_r;
  logic [SlotW-1:0] slot_r;
  func_t func_r;
  logic ok_r, out_v_r, out_ok_r, prog_r;
  logic [SIW-1:0] idx_r;
  logic [SIW:0] pass_r;

  // claim and held tables: one row (all types) per slot
  unit_t claim_mem [NUM_SLOTS][NUM_TYPES];
  unit_t held_mem  [NUM_SLOTS][NUM_TYPES];

  logic slot_ok;
  logic [SIW-1:0] s_idx;
  assign slot_ok = ({{(SIW+1 > SlotW ? SIW+1-SlotW : 1){1'b0}}, slot_r} < (SIW+1+SlotW)'(NUM_SLOTS));
  assign s_idx = SIW'(slot_r);

  // read port address; the last scan edge re-reads slot s for the apply step
  logic [SIW-1:0] rd_addr;
  assign rd_addr = (state_r == ST_SCAN && state_nxt == ST_SCAN) ? idx_r : s_idx;

  // lanes
  unit_t held_eff [NUM_TYPES];
  unit_t lane_work [NUM_TYPES];
  lane_stat_t lstat;
  logic at_s;
  assign at_s = (idx_r == s_idx);
  for (genvar t = 0; t < NUM_TYPES; t++) begin : g_he
    assign held_eff[t] = held_q_r[t] + ((state_r == ST_SCAN && at_s) ? amt_r[t] : '0);
  end

  bsa_lanes #(.NUM_TYPES(NUM_TYPES)) u_lanes (
    .claim_i(claim_q_r), .held_i(held_eff), .work_i(work_r),
    .work_o(lane_work), .stat_o(lstat)
  );

  // scan reads slot idx_r through a registered read; track which slot is in q
  logic [SIW-1:0] q_idx_r;
  logic q_valid_r;

  unit_t avail [NUM_TYPES];
  logic req_ok, new_ok;
  always_comb begin
    req_ok = 1'b1;
    new_ok = 1'b1;
    for (int t = 0; t < NUM_TYPES; t++) begin
      avail[t] = (total_r[t] > held_tot_r[t]) ? total_r[t] - held_tot_r[t] : '0;
      if (amt_r[t] > total_r[t]) new_ok = 1'b0;
      if (({1'b0, held_q_r[t]} + {1'b0, amt_r[t]}) > {1'b0, claim_q_r[t]}) req_ok = 1'b0;
      if (amt_r[t] > avail[t]) req_ok = 1'b0;
    end
  end

  logic last_slot;
  assign last_slot = (idx_r == SIW'(NUM_SLOTS - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_ch.valid) state_nxt = ST_RD;
      ST_RD:    state_nxt = ST_CHK;
      ST_CHK:   state_nxt = (func_r == FUNC_REQ && slot_ok && in_use_r[s_idx] && req_ok)
                            ? ST_SCAN : ST_APPLY;
      ST_SCAN:  if (q_valid_r && last_slot && q_idx_r == idx_r &&
                    (!(prog_r || (!fin_r[idx_r] && lstat.fits)) ||
                     pass_r == (SIW+1)'(NUM_SLOTS - 1)))
                  state_nxt = ST_APPLY;
      ST_APPLY: state_nxt = ST_OUT;
      ST_OUT:   if (!out_v_r || out_ch.ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = out_v_r;
  assign out_ch.ok    = out_ok_r;

  always_ff @(posedge clk) begin
    claim_q_r <= claim_mem[rd_addr];
    held_q_r  <= held_mem[rd_addr];
    q_idx_r   <= rd_addr;
    if (in_ch.valid && in_ch.ready) begin
      func_r <= func_t'(in_ch.func);
      slot_r <= in_ch.slot;
      amt_r[0] <= in_ch.amount_0;
      if (NUM_TYPES > 1) amt_r[1 % NUM_TYPES] <= in_ch.amount_1;
      if (NUM_TYPES > 2) amt_r[2 % NUM_TYPES] <= in_ch.amount_2;
      if (NUM_TYPES > 3) amt_r[3 % NUM_TYPES] <= in_ch.amount_3;
      for (int t = NumRegs; t < NUM_TYPES; t++) amt_r[t] <= '0;
    end
    if (state_r == ST_APPLY && slot_ok && ok_r) begin
      for (int t = 0; t < NUM_TYPES; t++) begin
        case (func_r)
          FUNC_NEW:  begin claim_mem[s_idx][t] <= amt_r[t]; held_mem[s_idx][t] <= '0; end
          FUNC_REQ:  held_mem[s_idx][t] <= held_q_r[t] + amt_r[t];
          FUNC_TERM: held_mem[s_idx][t] <= '0;
          default:   ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      in_use_r <= '0;
      fin_r <= '0;
      out_v_r <= 1'b0;
      out_ok_r <= 1'b0;
      ok_r <= 1'b0;
      idx_r <= '0;
      pass_r <= '0;
      prog_r <= 1'b0;
      q_valid_r <= 1'b0;
      for (int t = 0; t < NUM_TYPES; t++) begin
        total_r[t] <= '0;
        held_tot_r[t] <= '0;
        work_r[t] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we && ({1'b0, cfg_idx} < (CfgIdxW+1)'(NUM_TYPES)))
        total_r[cfg_idx] <= cfg_data;
      // output register: load when empty or being drained
      if (state_r == ST_OUT && (!out_v_r || out_ch.ready)) begin
        out_v_r  <= 1'b1;
        out_ok_r <= ok_r;
      end else if (out_ch.valid && out_ch.ready) begin
        out_v_r <= 1'b0;
      end
      case (state_r)
        ST_CHK: begin
          ok_r <= 1'b0;
          if (slot_ok) begin
            case (func_r)
              FUNC_NEW:  ok_r <= !in_use_r[s_idx] && new_ok;
              FUNC_TERM: ok_r <= in_use_r[s_idx];
              default:   ok_r <= 1'b0;
            endcase
          end
          if (state_nxt == ST_SCAN) begin
            for (int t = 0; t < NUM_TYPES; t++) work_r[t] <= avail[t] - amt_r[t];
            fin_r <= ~in_use_r;
            idx_r <= '0;
            pass_r <= '0;
            prog_r <= 1'b0;
            q_valid_r <= 1'b0;
          end
        end
        ST_SCAN: begin
          // wait for the registered read of slot idx_r
          if (!q_valid_r || q_idx_r != idx_r) begin
            q_valid_r <= 1'b1;
          end else begin
            q_valid_r <= 1'b0;
            if (!fin_r[idx_r] && lstat.fits) begin
              fin_r[idx_r] <= 1'b1;
              work_r <= lane_work;
            end
            if (last_slot) begin
              idx_r <= '0;
              pass_r <= pass_r + 1'b1;
              prog_r <= 1'b0;
              if (state_nxt == ST_APPLY) begin
                ok_r <= &(fin_r | (NUM_SLOTS'(!fin_r[idx_r] && lstat.fits) << idx_r));
              end
            end else begin
              idx_r <= idx_r + 1'b1;
              prog_r <= prog_r || (!fin_r[idx_r] && lstat.fits);
            end
          end
        end
        ST_APPLY: begin
          if (ok_r) begin
            case (func_r)
              FUNC_NEW:  in_use_r[s_idx] <= 1'b1;
              FUNC_REQ:  for (int t = 0; t < NUM_TYPES; t++)
                           held_tot_r[t] <= held_tot_r[t] + amt_r[t];
              FUNC_TERM: begin
                in_use_r[s_idx] <= 1'b0;
                for (int t = 0; t < NUM_TYPES; t++)
                  held_tot_r[t] <= (held_tot_r[t] > held_q_r[t])
                                   ? held_tot_r[t] - held_q_r[t] : '0;
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // scan read data must match the slot it is used for
  a_q_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && q_valid_r) |-> (q_idx_r == idx_r))
    else $error("scan read mismatch");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ch.ready) |=> (out_v_r && $stable(out_ok_r)))
    else $error("result changed while stalled");
  a_out_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(state_r) == ST_OUT) else $error("result without apply");
endmodule

### dv/tb_bankers_safety_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bankers_safety_allocator
// Self-checking bench for the Banker's-algorithm allocator: a directed set of
// claims, requests and terminations, then phases of random command streams
// under several resource totals. Each result is checked against an in-bench
// model of the slot table and its safety scan.
// ----------------------------------------------------------------------------
module tb_bankers_safety_allocator;
  import bsa_pkg::*;

  localparam int NSlots      = DefNumSlots;
  localparam int NTypes      = DefNumTypes;
  localparam int SettleTicks = 300;   // quiet cycles after the last result
  localparam int RandPerPhase = 280;
  localparam int MaxUnit     = 65535;

  typedef unit_t amt_vec_t [NTypes];

  // --------------------------------------------------------------------------
  class alloc_scoreboard;
    int unsigned total[NTypes];
    int unsigned held_sum[NTypes];
    int unsigned claim[NSlots][NTypes];
    int unsigned held[NSlots][NTypes];
    int unsigned work[NTypes];
    bit          in_use[NSlots];
    bit          done_mark[NSlots];
    bit          ok_q[$];
    int          mismatches;
    int          n_cmd[4];
    int          n_granted;

    function int unsigned avail(int t);
      return (total[t] > held_sum[t]) ? total[t] - held_sum[t] : 0;
    endfunction

    // tentative grant of a to slot s, then repeated passes looking for
    // unfinished slots whose remaining need fits the work vector
    function bit scan_safe(int s, amt_vec_t a);
      bit progress;
      bit fits;
      int unsigned h;
      for (int t = 0; t < NTypes; t++) work[t] = avail(t) - a[t];
      for (int i = 0; i < NSlots; i++) done_mark[i] = !in_use[i];
      for (int p = 0; p < NSlots; p++) begin
        progress = 0;
        for (int i = 0; i < NSlots; i++) begin
          if (done_mark[i]) continue;
          fits = 1;
          for (int t = 0; t < NTypes; t++) begin
            h = held[i][t] + ((i == s) ? a[t] : 0);
            if (claim[i][t] - h > work[t]) fits = 0;
          end
          if (fits) begin
            progress = 1;
            done_mark[i] = 1;
            for (int t = 0; t < NTypes; t++) begin
              h = work[t] + held[i][t] + ((i == s) ? a[t] : 0);
              work[t] = (h > MaxUnit) ? MaxUnit : h;
            end
          end
        end
        if (!progress) break;
      end
      foreach (done_mark[i]) if (!done_mark[i]) return 0;
      return 1;
    endfunction

    function void note_input(func_t f, int s, amt_vec_t a);
      bit ok;
      ok = 0;
      n_cmd[f]++;
      case (f)
        FUNC_NEW: begin
          if (!in_use[s]) begin
            ok = 1;
            for (int t = 0; t < NTypes; t++) if (a[t] > total[t]) ok = 0;
            if (ok) begin
              in_use[s] = 1;
              for (int t = 0; t < NTypes; t++) begin
                claim[s][t] = a[t];
                held[s][t]  = 0;
              end
            end
          end
        end
        FUNC_REQ: begin
          if (in_use[s]) begin
            ok = 1;
            for (int t = 0; t < NTypes; t++)
              if (held[s][t] + a[t] > claim[s][t] || a[t] > avail(t)) ok = 0;
            if (ok) ok = scan_safe(s, a);
            if (ok) begin
              n_granted++;
              for (int t = 0; t < NTypes; t++) begin
                held[s][t] += a[t];
                held_sum[t] = (held_sum[t] + a[t]) & MaxUnit;
              end
            end
          end
        end
        FUNC_TERM: begin
          if (in_use[s]) begin
            ok = 1;
            for (int t = 0; t < NTypes; t++) begin
              held_sum[t] = (held_sum[t] > held[s][t]) ? held_sum[t] - held[s][t] : 0;
              held[s][t]  = 0;
            end
            in_use[s] = 0;
          end
        end
        default: ok = 0;
      endcase
      ok_q = {ok_q, ok};
    endfunction

    function void check_result(bit ok);
      bit exp_ok;
      if (ok_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result ok=%0b with no pending item", ok);
        return;
      end
      exp_ok = ok_q.pop_front();
      if (ok !== exp_ok) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: ok expected %0b, got %0b", exp_ok, ok);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [UnitW-1:0]   cfg_data = '0;

  bsa_in_if  in_ch ();
  bsa_out_if out_ch ();

  bankers_safety_allocator i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  alloc_scoreboard sb = new();
  int hold_cycles = 0;
  int burst_left  = 0;
  bit no_gaps     = 0;

  // result side: stall pattern that changes every so often, plus long hold-offs
  initial begin
    int rx_mode;
    int rx_tick;
    rx_mode = 0;
    rx_tick = 0;
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        case (rx_mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 1) == 0);
          default: out_ch.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
      rx_tick++;
      if (rx_tick % 97 == 0) rx_mode = $urandom_range(0, 2);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.ok);
  end

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_cmd(func_t f, int s, amt_vec_t a);
    if (!no_gaps && burst_left <= 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_ch.valid    <= 1'b1;
    in_ch.func     <= f;
    in_ch.slot     <= s[SlotW-1:0];
    in_ch.amount_0 <= a[0];
    in_ch.amount_1 <= a[1];
    in_ch.amount_2 <= a[2];
    in_ch.amount_3 <= a[3];
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(f, s, a);
    @(negedge clk);
    burst_left--;
  endtask

  // lower valid, wait for every outstanding result, then let the block settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.ok_q.size() != 0) @(negedge clk);
    repeat (SettleTicks) @(negedge clk);
  endtask

  task automatic write_totals(int unsigned v0, int unsigned v1, int unsigned v2,
                              int unsigned v3);
    int unsigned v[NTypes];
    v = '{v0, v1, v2, v3};
    for (int t = 0; t < NTypes; t++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= t[CfgIdxW-1:0];
      cfg_data <= v[t][UnitW-1:0];
      @(negedge clk);
      sb.total[t] = v[t];
    end
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic amt_vec_t vec(int a0, int a1, int a2, int a3);
    amt_vec_t r;
    r = '{unit_t'(a0), unit_t'(a1), unit_t'(a2), unit_t'(a3)};
    return r;
  endfunction

  function automatic int pick_busy_slot();
    int busy[$];
    for (int i = 0; i < NSlots; i++) if (sb.in_use[i]) busy = {busy, i};
    if (busy.size() == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, NSlots - 1);
    return busy[$urandom_range(0, busy.size() - 1)];
  endfunction

  task automatic rand_cmd();
    int r;
    int s;
    int unsigned need;
    amt_vec_t a;
    r = $urandom_range(0, 99);
    for (int t = 0; t < NTypes; t++) a[t] = unit_t'($urandom());
    if (r < 2) begin
      send_cmd(FUNC_BAD, $urandom_range(0, NSlots - 1), a);
    end else if (r < 30) begin
      s = $urandom_range(0, NSlots - 1);
      if ($urandom_range(0, 6) != 0)
        for (int t = 0; t < NTypes; t++) a[t] = unit_t'($urandom_range(0, sb.total[t]));
      send_cmd(FUNC_NEW, s, a);
    end else if (r < 80) begin
      s = pick_busy_slot();
      if (sb.in_use[s] && $urandom_range(0, 6) != 0) begin
        for (int t = 0; t < NTypes; t++) begin
          need = sb.claim[s][t] - sb.held[s][t];
          // mostly a fraction of the need so that grants stay frequent
          a[t] = unit_t'($urandom_range(0, need) >> $urandom_range(0, 3));
          if ($urandom_range(0, 3) == 0) a[t] = '0;
        end
      end
      send_cmd(FUNC_REQ, s, a);
    end else begin
      send_cmd(FUNC_TERM, pick_busy_slot(), a);
    end
  endtask

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.func     = FUNC_NEW;
    in_ch.slot     = '0;
    in_ch.amount_0 = '0;
    in_ch.amount_1 = '0;
    in_ch.amount_2 = '0;
    in_ch.amount_3 = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: zero totals, then a small system
    no_gaps = 1;
    send_cmd(FUNC_NEW, 0, vec(0, 0, 0, 0));
    send_cmd(FUNC_NEW, 1, vec(1, 0, 0, 0));
    drain();
    write_totals(10, 10, 10, 10);
    send_cmd(FUNC_NEW, 1, vec(MaxUnit, MaxUnit, MaxUnit, MaxUnit));
    send_cmd(FUNC_NEW, 1, vec(10, 10, 10, 10));
    send_cmd(FUNC_NEW, 1, vec(1, 1, 1, 1));
    send_cmd(FUNC_NEW, 2, vec(6, 6, 6, 6));
    send_cmd(FUNC_REQ, 3, vec(1, 1, 1, 1));
    send_cmd(FUNC_TERM, 3, vec(0, 0, 0, 0));
    send_cmd(FUNC_BAD, 1, vec(1, 1, 1, 1));
    send_cmd(FUNC_REQ, 1, vec(11, 0, 0, 0));
    send_cmd(FUNC_REQ, 1, vec(5, 5, 5, 5));
    send_cmd(FUNC_REQ, 2, vec(4, 4, 4, 4));      // unsafe
    send_cmd(FUNC_REQ, 2, vec(6, 0, 0, 0));      // over available
    send_cmd(FUNC_REQ, 2, vec(1, 1, 1, 1));
    send_cmd(FUNC_NEW, 15, vec(10, 0, 10, 0));
    send_cmd(FUNC_REQ, 15, vec(0, 0, 0, 0));
    send_cmd(FUNC_TERM, 1, vec(MaxUnit, 0, MaxUnit, 0));
    send_cmd(FUNC_REQ, 15, vec(4, 0, 4, 0));
    send_cmd(FUNC_TERM, 0, vec(0, 0, 0, 0));
    send_cmd(FUNC_TERM, 2, vec(0, 0, 0, 0));
    send_cmd(FUNC_TERM, 15, vec(0, 0, 0, 0));
    drain();
    no_gaps = 0;

    // random phases under different totals
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_totals(MaxUnit, MaxUnit, MaxUnit, MaxUnit);
        1: write_totals(20, 12, 30, 8);
        2: write_totals($urandom_range(0, MaxUnit), $urandom_range(0, 100),
                        $urandom_range(0, 15), $urandom_range(1000, MaxUnit));
        3: write_totals(3, 0, MaxUnit, 7);       // likely below what is held
        default: write_totals($urandom_range(5, 40), $urandom_range(5, 40),
                              $urandom_range(5, 40), $urandom_range(5, 40));
      endcase
      no_gaps = (ph == 2);
      for (int n = 0; n < RandPerPhase; n++) begin
        if (n == 100 && ph == 1) hold_cycles = 600;  // block fills, input stalls
        if (n == 200) drain();
        rand_cmd();
      end
      drain();
    end

    $display("Covered %0d NEW, %0d REQUEST (%0d granted), %0d TERMINATE, %0d bad codes",
             sb.n_cmd[FUNC_NEW], sb.n_cmd[FUNC_REQ], sb.n_granted,
             sb.n_cmd[FUNC_TERM], sb.n_cmd[FUNC_BAD]);
    $display("over five total settings with receiver stalls; %0d mismatches",
             sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("ERROR: timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule

### files.f
hw/rtl/bsa_pkg.sv
hw/rtl/bsa_if.sv
hw/rtl/bsa_lanes.sv
hw/rtl/bankers_safety_allocator.sv
dv/tb_bankers_safety_allocator.sv
